/* design/rip_pkg.sv */
// Package for the regex infix-to-postfix converter.
// Holds the item and command types, the operator bytes and the sizing constants.
// No dependencies.
package rip_pkg;

  localparam int MAX_DEPTH  = 128;
  localparam int MAX_ALTS   = 31;
  localparam int MAX_LENGTH = 4095;
  localparam int CMDQ_DEPTH = 2;

  localparam int ALT_W  = $clog2(MAX_ALTS + 1);
  localparam int SP_W   = $clog2(MAX_DEPTH + 1);
  localparam int AW     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int LEN_W  = $clog2(MAX_LENGTH + 1);
  localparam int ATOM_W = 2;

  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_BAR    = 8'h7c;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_QUEST  = 8'h3f;

  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_DONE = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  typedef struct packed {
    logic       action;
    logic [7:0] symbol;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    kind_t      kind;
    logic       last;
  } out_item_t;

  // One command covers all results of one input transaction:
  // optional dot, optional character, a run of bars, optional done/error.
  typedef struct packed {
    logic             dot;
    logic             has_char;
    logic [7:0]       ch;
    logic [ALT_W-1:0] bars;
    logic             has_tail;
    kind_t            tail_kind;
  } cmd_t;

  typedef struct packed {
    logic [ALT_W-1:0]  alts;
    logic [ATOM_W-1:0] atoms;
  } stack_entry_t;

endpackage

/* design/rip_in_if.sv */
// Input channel of the converter: valid/ready handshake with a pattern item.
// Depends on rip_pkg.
interface rip_in_if;
  import rip_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* design/rip_out_if.sv */
// Output channel of the converter: valid/ready handshake with a result item.
// Depends on rip_pkg.
interface rip_out_if;
  import rip_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* design/rip_front.sv */
// Front end: accepts pattern items, checks errors, keeps the counts and the paren
// stack, and turns each transaction into at most one command. Depends on rip_pkg, rip_in_if.
module rip_front (
  input  logic         clk,
  input  logic         rst,
  rip_in_if.sink       items,
  output rip_pkg::cmd_t cmd,
  output logic         cmd_valid,
  input  logic         cmd_ready
);
  import rip_pkg::*;

  typedef enum logic [1:0] {
    ST_RUN = 2'b01,
    ST_POP = 2'b10
  } front_state_t;

  front_state_t      state, state_next;
  logic [ATOM_W-1:0] atom, atom_next;
  logic [ALT_W-1:0]  alt, alt_next;
  logic [SP_W-1:0]   sp, sp_next;
  logic [LEN_W-1:0]  len, len_next;
  logic              failed, failed_next;

  stack_entry_t      stack_mem [MAX_DEPTH];
  stack_entry_t      rd_entry;
  stack_entry_t      wr_entry;
  logic              push_en;
  logic              pop_rd;
  logic              acc;
  logic              is_err;
  logic [AW-1:0]     pop_addr;

  assign items.ready = (state == ST_RUN) && cmd_ready;
  assign acc         = items.valid && items.ready;
  assign pop_addr    = AW'(sp - SP_W'(1));

  always_comb begin
    state_next  = state;
    atom_next   = atom;
    alt_next    = alt;
    sp_next     = sp;
    len_next    = len;
    failed_next = failed;
    push_en     = 1'b0;
    pop_rd      = 1'b0;
    is_err      = 1'b0;
    cmd         = '0;
    wr_entry.alts  = alt;
    wr_entry.atoms = (atom == ATOM_W'(2)) ? ATOM_W'(1) : atom;

    if (state == ST_POP) begin
      alt_next   = rd_entry.alts;
      atom_next  = rd_entry.atoms + ATOM_W'(1);
      state_next = ST_RUN;
    end else if (acc) begin
      if (items.data.action) begin
        atom_next   = '0;
        alt_next    = '0;
        sp_next     = '0;
        len_next    = '0;
        failed_next = 1'b0;
        if (!failed) begin
          cmd.has_tail = 1'b1;
          if (sp != '0) begin
            cmd.tail_kind = KIND_ERR;
          end else begin
            cmd.dot       = (atom == ATOM_W'(2));
            cmd.bars      = alt;
            cmd.tail_kind = KIND_DONE;
          end
        end
      end else if (!failed) begin
        if (len >= LEN_W'(MAX_LENGTH)) begin
          is_err = 1'b1;
        end else begin
          len_next = len + LEN_W'(1);
          case (items.data.symbol)
            CH_LPAREN: begin
              if (sp >= SP_W'(MAX_DEPTH)) begin
                is_err = 1'b1;
              end else begin
                cmd.dot   = (atom == ATOM_W'(2));
                push_en   = 1'b1;
                sp_next   = sp + SP_W'(1);
                alt_next  = '0;
                atom_next = '0;
              end
            end
            CH_BAR: begin
              if (atom == '0 || alt >= ALT_W'(MAX_ALTS)) begin
                is_err = 1'b1;
              end else begin
                cmd.dot   = (atom == ATOM_W'(2));
                atom_next = '0;
                alt_next  = alt + ALT_W'(1);
              end
            end
            CH_RPAREN: begin
              if (sp == '0 || atom == '0) begin
                is_err = 1'b1;
              end else begin
                cmd.dot    = (atom == ATOM_W'(2));
                cmd.bars   = alt;
                sp_next    = sp - SP_W'(1);
                pop_rd     = 1'b1;
                state_next = ST_POP;
              end
            end
            CH_STAR, CH_PLUS, CH_QUEST: begin
              if (atom == '0) begin
                is_err = 1'b1;
              end else begin
                cmd.has_char = 1'b1;
                cmd.ch       = items.data.symbol;
              end
            end
            default: begin
              cmd.dot      = (atom == ATOM_W'(2));
              cmd.has_char = 1'b1;
              cmd.ch       = items.data.symbol;
              atom_next    = (atom == ATOM_W'(2)) ? ATOM_W'(2) : atom + ATOM_W'(1);
            end
          endcase
        end
        if (is_err) begin
          cmd           = '0;
          cmd.has_tail  = 1'b1;
          cmd.tail_kind = KIND_ERR;
          failed_next   = 1'b1;
        end
      end
    end
    cmd_valid = acc && (cmd.dot || cmd.has_char || cmd.has_tail || (cmd.bars != '0));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_RUN;
      atom   <= '0;
      alt    <= '0;
      sp     <= '0;
      len    <= '0;
      failed <= 1'b0;
    end else begin
      state  <= state_next;
      atom   <= atom_next;
      alt    <= alt_next;
      sp     <= sp_next;
      len    <= len_next;
      failed <= failed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      stack_mem[AW'(sp)] <= wr_entry;
    end
    if (pop_rd) begin
      rd_entry <= stack_mem[pop_addr];
    end
  end

  assert property (@(posedge clk) disable iff (rst) sp <= SP_W'(MAX_DEPTH))
    else $error("stack pointer beyond depth");
  assert property (@(posedge clk) disable iff (rst) atom <= ATOM_W'(2))
    else $error("atom count out of range");
  assert property (@(posedge clk) disable iff (rst) (state == ST_POP) |=> (state == ST_RUN))
    else $error("pop state held more than one cycle");

endmodule

/* design/rip_cmd_fifo.sv */
// Short command queue between front and back ends.
// Depends on rip_pkg.
module rip_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  rip_pkg::cmd_t wr_data,
  input  logic          wr_valid,
  output logic          wr_ready,
  output rip_pkg::cmd_t rd_data,
  output logic          rd_valid,
  input  logic          rd_ready
);
  import rip_pkg::*;

  localparam int PW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CW = $clog2(CMDQ_DEPTH + 1);

  cmd_t          q_mem [CMDQ_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr, do_rd;

  assign wr_ready = (count != CW'(CMDQ_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = q_mem[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      q_mem[wr_ptr] <= wr_data;
    end
  end

endmodule

/* design/rip_back.sv */
// Back end: expands each command into result items, one per cycle unless the
// output stalls, into an output register. Depends on rip_pkg, rip_out_if.
module rip_back (
  input  logic          clk,
  input  logic          rst,
  input  rip_pkg::cmd_t q_data,
  input  logic          q_valid,
  output logic          q_ready,
  rip_out_if.source     results
);
  import rip_pkg::*;

  cmd_t      cur, cur_after;
  logic      cur_valid;
  logic      rem;
  logic      advance;
  out_item_t item;
  out_item_t o_data;
  logic      o_valid;

  assign results.valid = o_valid;
  assign results.data  = o_data;
  assign advance       = !o_valid || results.ready;
  assign q_ready       = !cur_valid;

  always_comb begin
    cur_after     = cur;
    item.out_char = '0;
    item.kind     = KIND_CHAR;
    if (cur.dot) begin
      item.out_char = CH_DOT;
      cur_after.dot = 1'b0;
    end else if (cur.has_char) begin
      item.out_char      = cur.ch;
      cur_after.has_char = 1'b0;
    end else if (cur.bars != '0) begin
      item.out_char  = CH_BAR;
      cur_after.bars = cur.bars - ALT_W'(1);
    end else begin
      item.kind          = cur.tail_kind;
      cur_after.has_tail = 1'b0;
    end
    rem       = cur_after.dot || cur_after.has_char || (cur_after.bars != '0)
                || cur_after.has_tail;
    item.last = !rem;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid   <= 1'b0;
      cur_valid <= 1'b0;
    end else begin
      if (advance) begin
        o_valid <= cur_valid;
      end
      if (!cur_valid) begin
        cur_valid <= q_valid;
      end else if (advance) begin
        cur_valid <= rem;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!cur_valid) begin
      cur <= q_data;
    end else if (advance) begin
      cur    <= cur_after;
      o_data <= item;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (cur.dot || cur.has_char || (cur.bars != '0) || cur.has_tail))
    else $error("empty command held as pending");
  assert property (@(posedge clk) disable iff (rst) (q_valid && !cur_valid) |=> cur_valid)
    else $error("command taken but not loaded");
  assert property (@(posedge clk) disable iff (rst)
    (o_valid && !results.ready) |=> (o_valid && $stable(o_data)))
    else $error("result transaction changed while stalled");

endmodule

/* design/regex_infix_to_postfix.sv */
// Regex infix-to-postfix converter, top level. Depends on rip_pkg, rip_in_if,
// rip_out_if, rip_front, rip_cmd_fifo, rip_back.
// Path: a command is held in the queue, the back-end command register, then the output register.
// Input: one item per cycle while the queue has room; after ')', a stack-read state holds input.
// Output: back end loads a command, then emits its results; it takes no new command until done.
// Reset (rst, synchronous): clears counts, stack pointer, queue and output; stack data not cleared.
module regex_infix_to_postfix (
  input  logic      clk,
  input  logic      rst,
  rip_in_if.sink    items,
  rip_out_if.source results
);
  import rip_pkg::*;

  cmd_t f_cmd;
  logic f_valid, f_ready;
  cmd_t q_cmd;
  logic q_valid, q_ready;

  rip_front u_front (
    .clk       (clk),
    .rst       (rst),
    .items     (items),
    .cmd       (f_cmd),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready)
  );

  rip_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_data  (f_cmd),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .rd_data  (q_cmd),
    .rd_valid (q_valid),
    .rd_ready (q_ready)
  );

  rip_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_data  (q_cmd),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .results (results)
  );

endmodule
